### sv/link_keepalive_and_gap_resend_macros.svh
// Assertion helpers for the link keepalive block.
// Both sample on clk and stand down while rst_n is low.
`ifndef LINK_KEEPALIVE_AND_GAP_RESEND_MACROS_SVH
`define LINK_KEEPALIVE_AND_GAP_RESEND_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LKGR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LKGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lkgr_pkg.sv
package lkgr_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    SEQ_IDLE   = 5'b00001,
    SEQ_DECIDE = 5'b00010,
    SEQ_GAP    = 5'b00100,
    SEQ_EMIT_A = 5'b01000,
    SEQ_EMIT_B = 5'b10000
  } seq_t;

  // Link state as reported on the result channel
  typedef enum logic [1:0] {
    LINK_STOPPED   = 2'd0,
    LINK_WAITING   = 2'd1,
    LINK_CONNECTED = 2'd2
  } link_st_t;

  // Result actions
  typedef enum logic [2:0] {
    ACT_INIT       = 3'd0,
    ACT_PING       = 3'd1,
    ACT_RESEND     = 3'd2,
    ACT_RETRANSMIT = 3'd3,
    ACT_DELIVER    = 3'd4
  } act_t;

  // Input item functions
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_PACKET  = 2'd1;
  localparam logic [1:0] FUNC_CONNECT = 2'd2;
  localparam logic [1:0] FUNC_STOP    = 2'd3;

  // Control packet kinds
  localparam logic [2:0] KIND_HELLO   = 3'd0;
  localparam logic [2:0] KIND_GOODBYE = 3'd1;
  localparam logic [2:0] KIND_PONG    = 3'd2;
  localparam logic [2:0] KIND_RESEND  = 3'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PING_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_MAX_MISSED      = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT     = 2'd2;
  localparam logic [1:0] REG_CONTROL_CONN_ID = 2'd3;

  // Register reset values
  localparam logic [7:0] PING_INTERVAL_RST = 8'd5;
  localparam logic [7:0] MAX_MISSED_RST    = 8'd5;
  localparam logic [7:0] RETRY_LIMIT_RST   = 8'd5;
  localparam logic [7:0] SEND_COUNT_RST    = 8'd5;

endpackage

### sv/link_keepalive_and_gap_resend.sv
// Flow: an accepted item is decided in SEQ_DECIDE; its results are then registered from
// SEQ_GAP, SEQ_EMIT_A and SEQ_EMIT_B in order, one result per cycle while out_tready stays high.
// No new item is taken until the sequencer is back in SEQ_IDLE; a packet with a long gap
// gives up to MAX_RESEND_BURST resend results; the single incrementer walks the gap.
// Reset: synchronous on rst_n low; link stopped, counters and configuration registers at reset values.
`include "link_keepalive_and_gap_resend_macros.svh"

module link_keepalive_and_gap_resend #(
  parameter int MAX_RESEND_BURST = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // pack_id[15:0], is_resent[16], conn_id[32:17],
                                 // resend_target[48:33], zero fill
  input  logic [4:0]  in_tuser,  // func[1:0], packet_kind[4:2]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // packet_ref[15:0], link_state[17:16], zero fill
  output logic [2:0]  out_tuser, // action[2:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = $clog2(MAX_RESEND_BURST + 1);
  localparam logic [SW-1:0] SENT_LAST = SW'(MAX_RESEND_BURST - 1);

  // sequencer and link state
  lkgr_pkg::seq_t     seq_r, seq_nxt;
  lkgr_pkg::link_st_t link_r, link_nxt;
  logic [15:0] last_in_r, last_in_nxt;
  logic [7:0]  send_cnt_r, send_cnt_nxt;
  logic [7:0]  wait_cnt_r, wait_cnt_nxt;
  logic [7:0]  missed_r, missed_nxt;
  logic [7:0]  retries_r, retries_nxt;

  // configuration registers
  logic [7:0]  ping_int_r, ping_int_nxt;
  logic [7:0]  max_missed_r, max_missed_nxt;
  logic [7:0]  retry_lim_r, retry_lim_nxt;
  logic [15:0] ctrl_cid_r, ctrl_cid_nxt;

  // latched item
  logic [1:0]  func_r, func_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic        resent_r, resent_nxt;
  logic [15:0] cid_r, cid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [15:0] target_r, target_nxt;

  // gap walk and pending results
  logic [16:0]        next_r, next_nxt;
  logic [SW-1:0]      sent_r, sent_nxt;
  logic               gap_go;
  logic               a_v_r, a_v_nxt;
  lkgr_pkg::act_t     a_act_r, a_act_nxt;
  logic [15:0]        a_ref_r, a_ref_nxt;
  logic               b_v_r, b_v_nxt;

  // output register
  logic               out_v_r, out_v_nxt;
  lkgr_pkg::act_t     out_act_r, out_act_nxt;
  logic [15:0]        out_ref_r, out_ref_nxt;
  lkgr_pkg::link_st_t out_st_r, out_st_nxt;
  logic               out_last_r, out_last_nxt;

  // shared incrementer and compare
  logic [16:0] inc_op, inc_sum;
  logic        inc_lt, gap_cont, out_free;

  assign inc_op   = (seq_r == lkgr_pkg::SEQ_DECIDE) ? {1'b0, last_in_r} : next_r;
  assign inc_sum  = inc_op + 17'd1;
  assign inc_lt   = inc_sum < {1'b0, pid_r};
  assign gap_cont = inc_lt && (sent_r < SENT_LAST);
  assign out_free = !out_v_r || out_tready;

  assign in_tready  = (seq_r == lkgr_pkg::SEQ_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_st_r, out_ref_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  // Sequencer, state update and result emission
  always_comb begin
    seq_nxt        = seq_r;
    link_nxt       = link_r;
    last_in_nxt    = last_in_r;
    send_cnt_nxt   = send_cnt_r;
    wait_cnt_nxt   = wait_cnt_r;
    missed_nxt     = missed_r;
    retries_nxt    = retries_r;
    ping_int_nxt   = ping_int_r;
    max_missed_nxt = max_missed_r;
    retry_lim_nxt  = retry_lim_r;
    ctrl_cid_nxt   = ctrl_cid_r;
    func_nxt       = func_r;
    pid_nxt        = pid_r;
    resent_nxt     = resent_r;
    cid_nxt        = cid_r;
    kind_nxt       = kind_r;
    target_nxt     = target_r;
    next_nxt       = next_r;
    sent_nxt       = sent_r;
    gap_go         = 1'b0;
    a_v_nxt        = a_v_r;
    a_act_nxt      = a_act_r;
    a_ref_nxt      = a_ref_r;
    b_v_nxt        = b_v_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_act_nxt    = out_act_r;
    out_ref_nxt    = out_ref_r;
    out_st_nxt     = out_st_r;
    out_last_nxt   = out_last_r;

    // write configuration
    if (cfg_we) begin
      unique case (cfg_index)
        lkgr_pkg::REG_PING_INTERVAL:   ping_int_nxt   = cfg_data[7:0];
        lkgr_pkg::REG_MAX_MISSED:      max_missed_nxt = cfg_data[7:0];
        lkgr_pkg::REG_RETRY_LIMIT:     retry_lim_nxt  = cfg_data[7:0];
        lkgr_pkg::REG_CONTROL_CONN_ID: ctrl_cid_nxt   = cfg_data;
      endcase
    end

    unique case (seq_r)
      lkgr_pkg::SEQ_IDLE: begin
        // latch the item
        if (in_tvalid) begin
          func_nxt   = in_tuser[1:0];
          kind_nxt   = in_tuser[4:2];
          pid_nxt    = in_tdata[15:0];
          resent_nxt = in_tdata[16];
          cid_nxt    = in_tdata[32:17];
          target_nxt = in_tdata[48:33];
          seq_nxt    = lkgr_pkg::SEQ_DECIDE;
        end
      end

      lkgr_pkg::SEQ_DECIDE: begin
        a_v_nxt   = 1'b0;
        b_v_nxt   = 1'b0;
        a_act_nxt = lkgr_pkg::ACT_INIT;
        a_ref_nxt = 16'd0;
        next_nxt  = inc_sum;
        sent_nxt  = '0;
        unique case (func_r)
          lkgr_pkg::FUNC_TICK: begin
            if (link_r == lkgr_pkg::LINK_WAITING) begin
              // failed connect attempt
              if (retries_r <= 8'd1) begin
                retries_nxt = 8'd0;
                link_nxt    = lkgr_pkg::LINK_STOPPED;
              end else begin
                retries_nxt = retries_r - 8'd1;
                a_v_nxt     = 1'b1;
              end
            end else if (link_r == lkgr_pkg::LINK_CONNECTED) begin
              // count down the pong wait
              if (wait_cnt_r == 8'd1) begin
                wait_cnt_nxt = 8'd0;
                if (missed_r != 8'hff) missed_nxt = missed_r + 8'd1;
              end else if (wait_cnt_r > 8'd1) begin
                wait_cnt_nxt = wait_cnt_r - 8'd1;
              end
              // count down to the next ping
              if (send_cnt_r == 8'd1) begin
                a_v_nxt      = 1'b1;
                a_act_nxt    = lkgr_pkg::ACT_PING;
                wait_cnt_nxt = ping_int_r;
                send_cnt_nxt = 8'd0;
              end else if (send_cnt_r > 8'd1) begin
                send_cnt_nxt = send_cnt_r - 8'd1;
              end
              // link lost: reconnect
              if (wait_cnt_r == 8'd1 && missed_nxt > max_missed_r) begin
                b_v_nxt  = 1'b1;
                link_nxt = lkgr_pkg::LINK_WAITING;
              end
            end
          end

          lkgr_pkg::FUNC_PACKET: begin
            if (link_r != lkgr_pkg::LINK_STOPPED) begin
              send_cnt_nxt = ping_int_r;
              wait_cnt_nxt = 8'd0;
              if (!resent_r) begin
                gap_go      = inc_lt;
                last_in_nxt = pid_r;
              end
              if (cid_r == ctrl_cid_r) begin
                priority case (kind_r)
                  lkgr_pkg::KIND_HELLO: begin
                    link_nxt     = lkgr_pkg::LINK_CONNECTED;
                    a_v_nxt      = 1'b1;
                    a_act_nxt    = lkgr_pkg::ACT_PING;
                    wait_cnt_nxt = ping_int_r;
                    send_cnt_nxt = 8'd0;
                  end
                  lkgr_pkg::KIND_GOODBYE: link_nxt = lkgr_pkg::LINK_STOPPED;
                  lkgr_pkg::KIND_PONG:    missed_nxt = 8'd0;
                  lkgr_pkg::KIND_RESEND: begin
                    a_v_nxt   = 1'b1;
                    a_act_nxt = lkgr_pkg::ACT_RETRANSMIT;
                    a_ref_nxt = target_r;
                  end
                  default: ;
                endcase
              end else begin
                a_v_nxt   = 1'b1;
                a_act_nxt = lkgr_pkg::ACT_DELIVER;
                a_ref_nxt = cid_r;
              end
            end
          end

          lkgr_pkg::FUNC_CONNECT: begin
            if (link_r == lkgr_pkg::LINK_STOPPED) begin
              retries_nxt = retry_lim_r;
              a_v_nxt     = 1'b1;
              link_nxt    = lkgr_pkg::LINK_WAITING;
            end
          end

          lkgr_pkg::FUNC_STOP: link_nxt = lkgr_pkg::LINK_STOPPED;
        endcase

        // pick the first phase with work
        if (gap_go)       seq_nxt = lkgr_pkg::SEQ_GAP;
        else if (a_v_nxt) seq_nxt = lkgr_pkg::SEQ_EMIT_A;
        else if (b_v_nxt) seq_nxt = lkgr_pkg::SEQ_EMIT_B;
        else              seq_nxt = lkgr_pkg::SEQ_IDLE;
      end

      lkgr_pkg::SEQ_GAP: begin
        // request one skipped id per cycle while the output register is free
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_act_nxt  = lkgr_pkg::ACT_RESEND;
          out_ref_nxt  = next_r[15:0];
          out_st_nxt   = link_r;
          out_last_nxt = !gap_cont && !a_v_r && !b_v_r;
          next_nxt     = inc_sum;
          sent_nxt     = sent_r + SW'(1);
          if (!gap_cont) begin
            if (a_v_r)      seq_nxt = lkgr_pkg::SEQ_EMIT_A;
            else if (b_v_r) seq_nxt = lkgr_pkg::SEQ_EMIT_B;
            else            seq_nxt = lkgr_pkg::SEQ_IDLE;
          end
        end
      end

      lkgr_pkg::SEQ_EMIT_A: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_act_nxt  = a_act_r;
          out_ref_nxt  = a_ref_r;
          out_st_nxt   = link_r;
          out_last_nxt = !b_v_r;
          seq_nxt      = b_v_r ? lkgr_pkg::SEQ_EMIT_B : lkgr_pkg::SEQ_IDLE;
        end
      end

      lkgr_pkg::SEQ_EMIT_B: begin
        // reconnect after link loss
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_act_nxt  = lkgr_pkg::ACT_INIT;
          out_ref_nxt  = 16'd0;
          out_st_nxt   = link_r;
          out_last_nxt = 1'b1;
          seq_nxt      = lkgr_pkg::SEQ_IDLE;
        end
      end

      default: seq_nxt = lkgr_pkg::SEQ_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= lkgr_pkg::SEQ_IDLE;
      link_r       <= lkgr_pkg::LINK_STOPPED;
      last_in_r    <= 16'd0;
      send_cnt_r   <= lkgr_pkg::SEND_COUNT_RST;
      wait_cnt_r   <= 8'd0;
      missed_r     <= 8'd0;
      retries_r    <= lkgr_pkg::RETRY_LIMIT_RST;
      ping_int_r   <= lkgr_pkg::PING_INTERVAL_RST;
      max_missed_r <= lkgr_pkg::MAX_MISSED_RST;
      retry_lim_r  <= lkgr_pkg::RETRY_LIMIT_RST;
      ctrl_cid_r   <= 16'd0;
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      seq_r        <= seq_nxt;
      link_r       <= link_nxt;
      last_in_r    <= last_in_nxt;
      send_cnt_r   <= send_cnt_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      missed_r     <= missed_nxt;
      retries_r    <= retries_nxt;
      ping_int_r   <= ping_int_nxt;
      max_missed_r <= max_missed_nxt;
      retry_lim_r  <= retry_lim_nxt;
      ctrl_cid_r   <= ctrl_cid_nxt;
      a_v_r        <= a_v_nxt;
      b_v_r        <= b_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    pid_r      <= pid_nxt;
    resent_r   <= resent_nxt;
    cid_r      <= cid_nxt;
    kind_r     <= kind_nxt;
    target_r   <= target_nxt;
    next_r     <= next_nxt;
    sent_r     <= sent_nxt;
    a_act_r    <= a_act_nxt;
    a_ref_r    <= a_ref_nxt;
    out_act_r  <= out_act_nxt;
    out_ref_r  <= out_ref_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  `LKGR_ASSERT_NEXT(a_accept_decides, in_tvalid && in_tready, seq_r == lkgr_pkg::SEQ_DECIDE, "accepted item not decided")
  `LKGR_ASSERT_SAME(a_gap_below_pid, seq_r == lkgr_pkg::SEQ_GAP, next_r < {1'b0, pid_r}, "resend id beyond arrived packet")
  `LKGR_ASSERT_SAME(a_gap_capped, seq_r == lkgr_pkg::SEQ_GAP, sent_r <= SENT_LAST, "resend burst over cap")
  `LKGR_ASSERT_SAME(a_init_waiting, out_v_r && out_act_r == lkgr_pkg::ACT_INIT, out_st_r == lkgr_pkg::LINK_WAITING, "init sent outside waiting state")

endmodule
